// ----- sv/sfms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_pkg
// shared types, constants and the case fold helper of the substring search
// ----------------------------------------------------------------------------
package sfms_pkg;

   localparam int CHAR_W       = 16;
   localparam int INDEX_W      = 20;
   localparam int TAIL_W       = 21;
   localparam int LEN_W        = 5;
   localparam int NEEDLE_CHARS = 16;
   localparam int NIDX_W       = 4;
   localparam int WORD_W       = 64;
   localparam int CSR_IDX_W    = 3;

   localparam int DEFAULT_MAX_NEEDLE   = 16;
   localparam int DEFAULT_MAX_HAYSTACK = 1048576;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_WORD0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_WORD1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_WORD2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_WORD3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_CASE    = 3'd5;

   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 16'h0041;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 16'h005A;
   localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 16'h0020;

   typedef logic [NEEDLE_CHARS-1:0][CHAR_W-1:0] needle_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_index;
      logic [TAIL_W-1:0]  tail_length;
   } rsp_type;

   typedef struct packed {
      needle_type        needle;
      logic [LEN_W-1:0]  length;
      logic              fold;
   } cfg_type;

   typedef struct packed {
      logic    step;
      req_type item;
   } step_type;

   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                   input logic en);
      logic [CHAR_W-1:0] r;
      r = c;
      if (en && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
         r = c + ASCII_CASE_OFS;
      end
      return r;
   endfunction

endpackage

// ----- sv/sfms_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_match
// compares the newest window characters against the needle, one lane each
// ----------------------------------------------------------------------------
module sfms_match #(
   parameter int MAX_NEEDLE = sfms_pkg::DEFAULT_MAX_NEEDLE
) (
   input  sfms_pkg::cfg_type                               cfg,
   input  logic [sfms_pkg::LEN_W-1:0]                      used_len,
   input  logic [MAX_NEEDLE-1:0][sfms_pkg::CHAR_W-1:0]     window,
   output logic                                            match
);
   import sfms_pkg::*;

   logic [MAX_NEEDLE-1:0] lane_ok;

   // lane j holds the window character at age j; it lines up with needle
   // character used_len-1-j
   always_comb begin
      logic [LEN_W-1:0] nidx;
      logic             lane_on;
      for (int j = 0; j < MAX_NEEDLE; j++) begin
         lane_on = LEN_W'(j) < used_len;
         nidx    = used_len - LEN_W'(j) - LEN_W'(1);
         lane_ok[j] = !lane_on ||
                      (fold_char(window[j], cfg.fold) ==
                       fold_char(cfg.needle[nidx[NIDX_W-1:0]], cfg.fold));
      end
   end

   assign match = &lane_ok;

endmodule

// ----- sv/sfms_track.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfms_track
// character window, position count and first match record of one haystack
// ----------------------------------------------------------------------------
module sfms_track #(
   parameter int MAX_NEEDLE   = sfms_pkg::DEFAULT_MAX_NEEDLE,
   parameter int MAX_HAYSTACK = sfms_pkg::DEFAULT_MAX_HAYSTACK
) (
   input  logic               clock,
   input  logic               reset,
   input  sfms_pkg::cfg_type  cfg,
   input  sfms_pkg::step_type ctl,
   output sfms_pkg::rsp_type  result
);
   import sfms_pkg::*;

   localparam int POS_W  = $clog2(MAX_HAYSTACK + 1);
   localparam int DIFF_W = (POS_W > TAIL_W) ? POS_W : TAIL_W;

   logic [MAX_NEEDLE-1:0][CHAR_W-1:0] window_ff, window_in, shifted;
   logic [POS_W-1:0]                  pos_ff, pos_in, pos_next;
   logic                              hit_ff, hit_in, hit_next;
   logic [INDEX_W-1:0]                start_ff, start_in, start_next;
   logic [LEN_W-1:0]                  used_len;
   logic                              room, advance, match, hit_now;
   logic [DIFF_W-1:0]                 start_wide, tail_wide;

   always_comb begin
      if (cfg.length == '0) begin
         used_len = LEN_W'(1);
      end else if (cfg.length > LEN_W'(MAX_NEEDLE)) begin
         used_len = LEN_W'(MAX_NEEDLE);
      end else begin
         used_len = cfg.length;
      end
   end

   always_comb begin
      shifted[0] = ctl.item.character;
      for (int j = 1; j < MAX_NEEDLE; j++) begin
         shifted[j] = window_ff[j-1];
      end
   end

   sfms_match #(
      .MAX_NEEDLE (MAX_NEEDLE)
   ) u_match (
      .cfg      (cfg),
      .used_len (used_len),
      .window   (shifted),
      .match    (match)
   );

   // past the length limit characters are dropped
   assign room     = pos_ff < POS_W'(MAX_HAYSTACK);
   assign advance  = ctl.step && room;
   assign pos_next = advance ? pos_ff + POS_W'(1) : pos_ff;
   assign hit_now  = advance && !hit_ff && (DIFF_W'(pos_next) >= DIFF_W'(used_len)) && match;

   assign start_wide = DIFF_W'(pos_next) - DIFF_W'(used_len);
   assign hit_next   = hit_ff || hit_now;
   assign start_next = hit_now ? start_wide[INDEX_W-1:0] : start_ff;
   assign tail_wide  = DIFF_W'(pos_next) - DIFF_W'(start_next);

   always_comb begin
      result.found       = hit_next;
      result.match_index = hit_next ? start_next : '0;
      result.tail_length = hit_next ? tail_wide[TAIL_W-1:0] : '0;
   end

   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      hit_in    = hit_ff;
      start_in  = start_ff;
      if (ctl.step) begin
         if (ctl.item.last) begin
            window_in = '0;
            pos_in    = '0;
            hit_in    = 1'b0;
            start_in  = '0;
         end else begin
            window_in = advance ? shifted : window_ff;
            pos_in    = pos_next;
            hit_in    = hit_next;
            start_in  = start_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         pos_ff    <= '0;
         hit_ff    <= 1'b0;
         start_ff  <= '0;
      end else begin
         window_ff <= window_in;
         pos_ff    <= pos_in;
         hit_ff    <= hit_in;
         start_ff  <= start_in;
      end
   end

`ifndef SYNTH
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      ctl.step && ctl.item.last |=> pos_ff == '0 && !hit_ff)
      else $error("search state not cleared after last character");

   a_hit_sticky: assert property (@(posedge clock) disable iff (reset)
      hit_ff && !(ctl.step && ctl.item.last) |=> hit_ff && $stable(start_ff))
      else $error("first match record changed inside a haystack");

   a_window_head: assert property (@(posedge clock) disable iff (reset)
      advance && !ctl.item.last |=> window_ff[0] == $past(ctl.item.character))
      else $error("window head does not hold the newest character");
`endif

endmodule

// ----- sv/substring_first_match_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_first_match_search
// streams haystack characters and reports the first occurrence of a needle
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------
//  req     | in        | valid / stall    | character, last
//  rsp     | out       | valid / stall    | found, match_index, tail_length
//  csr     | in        | valid / ready    | register index, 64-bit write data
//
//  one character per cycle sustained, but for a stall on a last character; a character
//  is held in the input register and its result, on a last character, is then
//  loaded into the output register
//  the window compare is a single pass of parallel lane comparators
//  reset is synchronous, active high; needle registers return to zero, length 1
//  req stalls only when a last character meets a full, stalled output register
// ----------------------------------------------------------------------------
module substring_first_match_search #(
   parameter int MAX_NEEDLE   = sfms_pkg::DEFAULT_MAX_NEEDLE,
   parameter int MAX_HAYSTACK = sfms_pkg::DEFAULT_MAX_HAYSTACK
) (
   input  logic                            clock,
   input  logic                            reset,
   // haystack characters
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sfms_pkg::req_type               req_data,
   // search results
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sfms_pkg::rsp_type               rsp_data,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sfms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfms_pkg::WORD_W-1:0]     csr_data
);
   import sfms_pkg::*;

   localparam int WORD_CHARS = WORD_W / CHAR_W;

   cfg_type  cfg_ff, cfg_in;
   logic     s1_valid_ff, s1_valid_in;
   req_type  s1_item_ff, s1_item_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   step_type ctl;
   rsp_type  result;
   logic     req_xfer, process, rsp_xfer, csr_xfer;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_comb begin
      logic [NIDX_W-1:0] slot;
      slot   = '0;
      cfg_in = cfg_ff;
      if (csr_xfer) begin
         case (csr_index)
            CSR_NEEDLE_WORD0, CSR_NEEDLE_WORD1,
            CSR_NEEDLE_WORD2, CSR_NEEDLE_WORD3: begin
               // four characters per word, lowest character in the low bits
               for (int k = 0; k < WORD_CHARS; k++) begin
                  slot = NIDX_W'(int'(csr_index) * WORD_CHARS + k);
                  cfg_in.needle[slot] = csr_data[k*CHAR_W +: CHAR_W];
               end
            end
            CSR_NEEDLE_LEN: begin
               cfg_in.length = csr_data[LEN_W-1:0];
            end
            CSR_FOLD_CASE: begin
               cfg_in.fold = csr_data[0];
            end
            default: begin
               // unmapped index, write ignored
            end
         endcase
      end
   end

   // ---------------------------------------------------------- handshake
   // a non-last character always moves on; a last one needs room at the output
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign process   = s1_valid_ff && !(s1_item_ff.last && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !process;
   assign req_xfer  = req_valid && !req_stall;

   assign s1_valid_in = req_xfer ? 1'b1 : (process ? 1'b0 : s1_valid_ff);
   assign s1_item_in  = req_xfer ? req_data : s1_item_ff;

   assign ctl.step = process;
   assign ctl.item = s1_item_ff;

   // ------------------------------------------------------ search state
   sfms_track #(
      .MAX_NEEDLE   (MAX_NEEDLE),
      .MAX_HAYSTACK (MAX_HAYSTACK)
   ) u_track (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .ctl    (ctl),
      .result (result)
   );

   // ----------------------------------------------------- output register
   // loaded only when empty or being emptied in the same cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (process && s1_item_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.needle <= '0;
         cfg_ff.length <= LEN_W'(1);
         cfg_ff.fold   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      process && s1_item_ff.last |=> rsp_valid)
      else $error("last character did not produce a result");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.match_index == '0 &&
                                       rsp_data.tail_length == '0)
      else $error("result without a match carries non-zero fields");

   a_plain_char_flows: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_item_ff.last |-> !req_stall)
      else $error("input stalled behind a character that gives no result");
`endif

endmodule
